// File: design/wl1dt_pkg.sv
// Shared types and constants of the weighted L1 distance transform.
package wl1dt_pkg;

    localparam int POS_W    = 7;
    localparam int WEIGHT_W = 30;
    localparam int VALUE_W  = 31;

    localparam logic [POS_W-1:0]   CELL_COUNT_RESET = 7'd64;
    localparam logic [VALUE_W-1:0] VALUE_INF        = 31'h7FFF_FFFF;

    typedef enum logic {
        OP_PLACE = 1'b0,
        OP_RUN   = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_BWD,
        BK_TURN,
        BK_FWD
    } t_back_state;

    // One command handed from the front end to the back end.
    typedef struct packed {
        logic                is_run;
        logic [POS_W-1:0]    position;
        logic [WEIGHT_W-1:0] weight;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_req;

endpackage

// File: design/wl1dt_if.sv
// Handshake interfaces for the input word and the result word.
interface wl1dt_item_if;
    logic                           valid;
    logic                           ready;
    logic                           opcode;
    logic [wl1dt_pkg::POS_W-1:0]    unit_position;
    logic [wl1dt_pkg::WEIGHT_W-1:0] unit_temperature;

    modport source (output valid, output opcode, output unit_position,
                    output unit_temperature, input ready);
    modport sink   (input valid, input opcode, input unit_position,
                    input unit_temperature, output ready);
endinterface

interface wl1dt_result_if;
    logic                          valid;
    logic                          ready;
    logic [wl1dt_pkg::POS_W-1:0]   cell_index;
    logic [wl1dt_pkg::VALUE_W-1:0] cell_value;
    logic                          covered;
    logic                          last;

    modport source (output valid, output cell_index, output cell_value,
                    output covered, output last, input ready);
    modport sink   (input valid, input cell_index, input cell_value,
                    input covered, input last, output ready);
endinterface

// File: design/wl1dt_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module wl1dt_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/wl1dt_queue.sv
// Short command queue between the front end and the back end.
module wl1dt_queue #(
    parameter int DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wl1dt_pkg::t_cmd_req i_push,
    output logic                o_full,
    input  logic                i_pop,
    output wl1dt_pkg::t_cmd_req o_head
);
    import wl1dt_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd               r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               do_push;
    logic               do_pop;

    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && (r_count != '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.cmd;
        end
    end

    assign o_full       = (r_count == CNT_W'(DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_mem[r_rd_ptr];
endmodule

// File: design/wl1dt_front.sv
// Front end: accepts input words, drops out-of-range places, queues commands.
module wl1dt_front (
    wl1dt_item_if.sink                  i_item,
    input  logic [wl1dt_pkg::POS_W-1:0] i_cells,
    input  logic                        i_full,
    output wl1dt_pkg::t_cmd_req         o_push
);
    import wl1dt_pkg::*;

    logic is_run;
    logic pos_ok;

    always_comb begin
        is_run = (i_item.opcode == OP_RUN);
        pos_ok = (i_item.unit_position != '0) && (i_item.unit_position <= i_cells);

        i_item.ready        = !i_full;
        o_push.valid        = i_item.valid && !i_full && (is_run || pos_ok);
        o_push.cmd.is_run   = is_run;
        o_push.cmd.position = i_item.unit_position;
        o_push.cmd.weight   = i_item.unit_temperature;
    end
endmodule

// File: design/wl1dt_back.sv
// Back end: source map, backward and forward sweeps, output register.
module wl1dt_back #(
    parameter int MAX_CELLS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [wl1dt_pkg::POS_W-1:0] i_cells,
    input  wl1dt_pkg::t_cmd_req         i_head,
    output logic                        o_pop,
    wl1dt_result_if.source              o_result
);
    import wl1dt_pkg::*;

    localparam int IDX_W = $clog2(MAX_CELLS);

    t_back_state          r_state, n_state;
    logic [MAX_CELLS-1:0] r_present, n_present;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [VALUE_W-1:0]   r_carry, n_carry;
    logic                 r_covered, n_covered;

    logic                 r_out_valid, n_out_valid;
    logic [POS_W-1:0]     r_out_index, n_out_index;
    logic [VALUE_W-1:0]   r_out_value, n_out_value;
    logic                 r_out_covered, n_out_covered;
    logic                 r_out_last, n_out_last;

    logic [POS_W-1:0]     cells_m1;
    logic [POS_W-1:0]     pos_m1;
    logic [IDX_W-1:0]     last_idx;
    logic [IDX_W-1:0]     cmd_idx;
    logic [MAX_CELLS-1:0] active_mask;
    logic                 any_present;
    logic [VALUE_W-1:0]   carry_inc;
    logic [VALUE_W-1:0]   bwd_source;
    logic [VALUE_W-1:0]   bwd_val;
    logic [VALUE_W-1:0]   fwd_val;
    logic                 out_free;

    logic                 weight_we;
    logic                 scratch_we;
    logic [WEIGHT_W-1:0]  weight_rdata;
    logic [VALUE_W-1:0]   scratch_rdata;

    assign cells_m1 = i_cells - POS_W'(1);
    assign pos_m1   = i_head.cmd.position - POS_W'(1);
    assign last_idx = cells_m1[IDX_W-1:0];
    assign cmd_idx  = pos_m1[IDX_W-1:0];

    always_comb begin
        for (int k = 0; k < MAX_CELLS; k++) begin
            active_mask[k] = (POS_W'(k) < i_cells);
        end
    end

    assign any_present = |(r_present & active_mask);

    // Infinity stays infinity; finite values never reach it.
    assign carry_inc  = (r_carry == VALUE_INF) ? VALUE_INF : r_carry + VALUE_W'(1);
    assign bwd_source = r_present[r_idx] ? {1'b0, weight_rdata} : VALUE_INF;
    assign bwd_val    = (bwd_source < carry_inc) ? bwd_source : carry_inc;
    assign fwd_val    = (scratch_rdata < carry_inc) ? scratch_rdata : carry_inc;
    assign out_free   = !r_out_valid || o_result.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_head.valid && i_head.cmd.is_run) begin
                    n_state = BK_BWD;
                end
            end
            BK_BWD: begin
                if (r_idx == '0) begin
                    n_state = BK_TURN;
                end
            end
            BK_TURN: begin
                n_state = BK_FWD;
            end
            BK_FWD: begin
                if (out_free && (r_idx == last_idx)) begin
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        n_idx         = r_idx;
        n_carry       = r_carry;
        n_covered     = r_covered;
        n_present     = r_present;
        n_out_valid   = r_out_valid && !o_result.ready;
        n_out_index   = r_out_index;
        n_out_value   = r_out_value;
        n_out_covered = r_out_covered;
        n_out_last    = r_out_last;
        o_pop         = 1'b0;
        weight_we     = 1'b0;
        scratch_we    = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    if (i_head.cmd.is_run) begin
                        n_idx     = last_idx;
                        n_carry   = VALUE_INF;
                        n_covered = any_present;
                    end else begin
                        weight_we          = 1'b1;
                        n_present[cmd_idx] = 1'b1;
                    end
                end
            end
            BK_BWD: begin
                scratch_we = 1'b1;
                n_carry    = bwd_val;
                if (r_idx != '0) begin
                    n_idx = r_idx - IDX_W'(1);
                end
            end
            BK_TURN: begin
                n_carry = VALUE_INF;
            end
            BK_FWD: begin
                if (out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_index   = {{(POS_W - IDX_W){1'b0}}, r_idx} + POS_W'(1);
                    n_out_value   = fwd_val;
                    n_out_covered = r_covered;
                    n_out_last    = (r_idx == last_idx);
                    n_carry       = fwd_val;
                    if (r_idx == last_idx) begin
                        n_present = '0;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_present   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_present   <= n_present;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx         <= n_idx;
        r_carry       <= n_carry;
        r_covered     <= n_covered;
        r_out_index   <= n_out_index;
        r_out_value   <= n_out_value;
        r_out_covered <= n_out_covered;
        r_out_last    <= n_out_last;
    end

    // Both memories are read at the next index, so read data always
    // matches the current index.
    wl1dt_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (MAX_CELLS)
    ) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (weight_we),
        .i_waddr (cmd_idx),
        .i_wdata (i_head.cmd.weight),
        .i_raddr (n_idx),
        .o_rdata (weight_rdata)
    );

    wl1dt_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_CELLS)
    ) u_scratch_ram (
        .i_clk   (i_clk),
        .i_we    (scratch_we),
        .i_waddr (r_idx),
        .i_wdata (bwd_val),
        .i_raddr (n_idx),
        .o_rdata (scratch_rdata)
    );

    assign o_result.valid      = r_out_valid;
    assign o_result.cell_index = r_out_index;
    assign o_result.cell_value = r_out_value;
    assign o_result.covered    = r_out_covered;
    assign o_result.last       = r_out_last;
endmodule

// File: design/weighted_l1_distance_transform.sv
// Top level of the weighted one-dimensional L1 distance transform.
// Throughput: one place word per cycle enters a two-entry queue while it has room and is retired
// by a single pop. A run of n cells takes a pop, a backward step per cell, a memory turnaround,
// then a forward step per cell that emits one result per cycle while the sink is ready.
// Reset (synchronous, active low) clears the queue, sequencer, source map and output register
// and sets the cell count to 64; the weight memory is not cleared.
module weighted_l1_distance_transform #(
    parameter int MAX_CELLS = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [wl1dt_pkg::POS_W-1:0] i_cfg_data,
    wl1dt_item_if.sink                  i_item,
    wl1dt_result_if.source              o_result
);
    import wl1dt_pkg::*;

    localparam logic [POS_W-1:0] CELLS_MAX = POS_W'(MAX_CELLS);

    logic [POS_W-1:0] r_cell_count;
    logic [POS_W-1:0] cells;
    t_cmd_req         push;
    t_cmd_req         head;
    logic             full;
    logic             pop;

    // The user must write the cell count register only while the block is idle (the block does
    // not enforce this), so the front and back ends both read it directly.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_count <= CELL_COUNT_RESET;
        end else if (i_cfg_we) begin
            r_cell_count <= i_cfg_data;
        end
    end

    // A count of zero acts as one cell, and a count beyond the row acts as
    // the full row.
    always_comb begin
        if (r_cell_count == '0) begin
            cells = POS_W'(1);
        end else if (r_cell_count > CELLS_MAX) begin
            cells = CELLS_MAX;
        end else begin
            cells = r_cell_count;
        end
    end

    // The front end takes every word while the queue has room. Places with
    // a position outside the active row are swallowed here.
    wl1dt_front u_front (
        .i_item  (i_item),
        .i_cells (cells),
        .i_full  (full),
        .o_push  (push)
    );

    wl1dt_queue #(
        .DEPTH (2)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_pop   (pop),
        .o_head  (head)
    );

    // The back end keeps the source map. A run sweeps from the last cell
    // down, storing the best value seen from the right, then sweeps up,
    // folding in the best value from the left and emitting each cell.
    wl1dt_back #(
        .MAX_CELLS (MAX_CELLS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cells  (cells),
        .i_head   (head),
        .o_pop    (pop),
        .o_result (o_result)
    );

    // A result always names a cell inside the active row.
    a_index_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.cell_index != '0) && (o_result.cell_index <= cells))
        else $error("result cell index outside the active row");

    // Without any source every value is the all-ones marker.
    a_uncovered_inf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.covered) |-> (o_result.cell_value == VALUE_INF))
        else $error("uncovered result carries a finite value");

    // With a source every value is finite.
    a_covered_finite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.covered) |-> (o_result.cell_value != VALUE_INF))
        else $error("covered result carries the all-ones marker");

    // Results of a run come out in increasing cell order with no gaps.
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.ready && !o_result.last) |=>
            (!o_result.valid ||
             (o_result.cell_index == POS_W'($past(o_result.cell_index) + POS_W'(1)))))
        else $error("result cell index did not advance by one");
endmodule
